// ===== rtl/periodic_task_deadline_tracker_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Periodic task deadline tracker: assertion macros
// Shared property forms for the checker of the tracker's ports.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_DEADLINE_TRACKER_UNIT_DEFINES_SVH
`define PERIODIC_TASK_DEADLINE_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication
`define PTDT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tracker check failed: same-cycle rule");

// next-cycle implication
`define PTDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tracker check failed: next-cycle rule");

`endif

// ===== rtl/ptdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic task deadline tracker: package
// Event codes, register indexes, microcode types and step addresses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptdt_pkg;

   localparam int FUNC_WIDTH      = 2;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int FIELD_WIDTH     = 32;
   localparam int STEP_WIDTH      = 4;
   localparam int STEP_COUNT      = 16;

   localparam logic [FUNC_WIDTH-1:0] FUNC_START = 2'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_STOP  = 2'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_RUN   = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INTERVAL      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INITIAL_WAIT  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_TRIGGERS  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CATCH_UP      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STRICT_PERIOD = 3'd4;

   localparam logic [CSR_DATA_WIDTH-1:0] INTERVAL_RESET = 32'd1000;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_START,
      OP_STOP,
      OP_COUNT,
      OP_LATE,
      OP_DIV,
      OP_BASE,
      OP_TARGET,
      OP_AVG,
      OP_KILL,
      OP_LAST,
      OP_PRED,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      SEQ_NEXT,
      SEQ_JUMP,
      SEQ_IF_LIMIT,
      SEQ_LOOP,
      SEQ_DISPATCH,
      SEQ_EMIT
   } seq_type;

   typedef struct packed {
      op_type                op;
      seq_type               seq;
      logic [STEP_WIDTH-1:0] target;
   } ucode_type;

   typedef struct packed {
      op_type op;
      logic   fire;
      logic   idle;
   } ctrl_type;

   typedef struct packed {
      logic                  req_valid;
      logic [FUNC_WIDTH-1:0] func;
      logic                  limit_hit;
      logic                  div_more;
      logic                  out_free;
   } stat_type;

   localparam logic [STEP_WIDTH-1:0] STEP_IDLE   = 4'd0;
   localparam logic [STEP_WIDTH-1:0] STEP_START  = 4'd1;
   localparam logic [STEP_WIDTH-1:0] STEP_STOP   = 4'd2;
   localparam logic [STEP_WIDTH-1:0] STEP_RUN    = 4'd3;
   localparam logic [STEP_WIDTH-1:0] STEP_LATE   = 4'd4;
   localparam logic [STEP_WIDTH-1:0] STEP_DIV    = 4'd5;
   localparam logic [STEP_WIDTH-1:0] STEP_BASE   = 4'd6;
   localparam logic [STEP_WIDTH-1:0] STEP_TARGET = 4'd7;
   localparam logic [STEP_WIDTH-1:0] STEP_AVG    = 4'd8;
   localparam logic [STEP_WIDTH-1:0] STEP_KILL   = 4'd9;
   localparam logic [STEP_WIDTH-1:0] STEP_LAST   = 4'd10;
   localparam logic [STEP_WIDTH-1:0] STEP_PRED   = 4'd11;
   localparam logic [STEP_WIDTH-1:0] STEP_EMIT   = 4'd12;

endpackage

// ===== rtl/periodic_task_deadline_tracker_unit.sv =====
// A start or stop event runs its step, then LAST, PRED and EMIT; an unused code
// goes to LAST. A run report counts, divides its lateness by the interval one
// remainder bit per cycle in the shift-subtract loop, then runs BASE to EMIT, or
// KILL to EMIT when the trigger limit is reached. The next item is taken in the
// cycle after the result is handed to the output register, so one item is in work at a time.
// Synchronous reset clears the configuration registers, task state, sequencer and output valid.
// ----------------------------------------------------------------------------
// Periodic task deadline tracker
// Microcoded datapath that schedules one periodic task from start, stop and
// run report items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_task_deadline_tracker_unit
   import ptdt_pkg::*;
#(
   parameter int TIME_WIDTH = 32
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [FUNC_WIDTH-1:0]      req_func,
   input  logic [FIELD_WIDTH-1:0]     req_start_time,
   input  logic [FIELD_WIDTH-1:0]     req_end_time,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [FIELD_WIDTH-1:0]     rsp_next_target,
   output logic                       rsp_enabled,
   output logic                       rsp_destroyed,
   output logic [FIELD_WIDTH-1:0]     rsp_trigger_total,
   output logic [FIELD_WIDTH-1:0]     rsp_last_duration,
   output logic [FIELD_WIDTH-1:0]     rsp_mean_duration,
   output logic [FIELD_WIDTH-1:0]     rsp_predicted_duration,
   output logic signed [FIELD_WIDTH-1:0] rsp_start_lateness
);

   localparam int TW        = TIME_WIDTH;
   localparam int CNT_WIDTH = $clog2(TIME_WIDTH + 1);

   ctrl_type ctrl;
   stat_type stat;

   // configuration
   logic [CSR_DATA_WIDTH-1:0] interval_ff, interval_in;
   logic [CSR_DATA_WIDTH-1:0] initial_wait_ff, initial_wait_in;
   logic [CSR_DATA_WIDTH-1:0] max_triggers_ff, max_triggers_in;
   logic                      catch_up_ff, catch_up_in;
   logic                      strict_period_ff, strict_period_in;

   // task state
   logic [TW-1:0]          next_target_ff, next_target_in;
   logic [TW-1:0]          last_target_ff, last_target_in;
   logic [TW-1:0]          last_start_ff, last_start_in;
   logic [TW-1:0]          last_end_ff, last_end_in;
   logic [TW-1:0]          average_ff, average_in;
   logic [FIELD_WIDTH-1:0] run_count_ff, run_count_in;
   logic                   enabled_ff, enabled_in;
   logic                   destroy_ff, destroy_in;

   // working registers
   logic [TW-1:0]        start_ff, start_in;
   logic [TW-1:0]        end_ff, end_in;
   logic [TW-1:0]        lat_ff, lat_in;
   logic [TW-1:0]        quo_ff, quo_in;
   logic [TW-1:0]        rem_ff, rem_in;
   logic [CNT_WIDTH-1:0] div_cnt_ff, div_cnt_in;
   logic [TW-1:0]        base_ff, base_in;
   logic [TW-1:0]        dur_ff, dur_in;
   logic [TW-1:0]        pred_ff, pred_in;
   logic [TW-1:0]        late_ff, late_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FIELD_WIDTH-1:0] rsp_next_target_ff, rsp_next_target_in;
   logic                   rsp_enabled_ff, rsp_enabled_in;
   logic                   rsp_destroyed_ff, rsp_destroyed_in;
   logic [FIELD_WIDTH-1:0] rsp_trigger_total_ff, rsp_trigger_total_in;
   logic [FIELD_WIDTH-1:0] rsp_last_duration_ff, rsp_last_duration_in;
   logic [FIELD_WIDTH-1:0] rsp_mean_duration_ff, rsp_mean_duration_in;
   logic [FIELD_WIDTH-1:0] rsp_pred_ff, rsp_pred_in;
   logic [FIELD_WIDTH-1:0] rsp_late_ff, rsp_late_in;

   logic [TW-1:0] period;
   logic [TW:0]   rem_shift;
   logic [TW:0]   rem_diff;
   logic [TW-1:0] lat_rem;
   logic [TW-1:0] avg_sum;
   logic          out_free;
   logic          emit_fire;

   assign period   = TW'(interval_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign stat.req_valid = req_valid;
   assign stat.func      = req_func;
   assign stat.limit_hit = (max_triggers_ff != '0) && (run_count_ff >= max_triggers_ff);
   assign stat.div_more  = (div_cnt_ff != CNT_WIDTH'(1));
   assign stat.out_free  = out_free;

   ptdt_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   assign req_stall = !ctrl.idle;
   assign emit_fire = ctrl.fire && (ctrl.op == OP_EMIT);

   assign rem_shift = {rem_ff, quo_ff[TW-1]};
   assign rem_diff  = rem_shift - {1'b0, period};
   assign lat_rem   = (period == '0) ? lat_ff : rem_ff;
   assign avg_sum   = average_ff + dur_ff;

   // configuration writes
   always_comb begin
      interval_in      = interval_ff;
      initial_wait_in  = initial_wait_ff;
      max_triggers_in  = max_triggers_ff;
      catch_up_in      = catch_up_ff;
      strict_period_in = strict_period_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_INTERVAL:      interval_in      = csr_data;
            CSR_INITIAL_WAIT:  initial_wait_in  = csr_data;
            CSR_MAX_TRIGGERS:  max_triggers_in  = csr_data;
            CSR_CATCH_UP:      catch_up_in      = csr_data[0];
            CSR_STRICT_PERIOD: strict_period_in = csr_data[0];
            default:           interval_in      = interval_ff;
         endcase
      end
   end

   // datapath, one operation per step
   always_comb begin
      next_target_in = next_target_ff;
      last_target_in = last_target_ff;
      last_start_in  = last_start_ff;
      last_end_in    = last_end_ff;
      average_in     = average_ff;
      run_count_in   = run_count_ff;
      enabled_in     = enabled_ff;
      destroy_in     = destroy_ff;
      start_in       = start_ff;
      end_in         = end_ff;
      lat_in         = lat_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      div_cnt_in     = div_cnt_ff;
      base_in        = base_ff;
      dur_in         = dur_ff;
      pred_in        = pred_ff;
      late_in        = late_ff;
      if (ctrl.fire) begin
         case (ctrl.op)
            OP_LOAD: begin
               start_in = TW'(req_start_time);
               end_in   = TW'(req_end_time);
            end
            OP_START: begin
               enabled_in     = 1'b1;
               next_target_in = start_ff + TW'(initial_wait_ff);
            end
            OP_STOP:  enabled_in   = 1'b0;
            OP_COUNT: run_count_in = run_count_ff + 1'b1;
            OP_LATE: begin
               lat_in     = start_ff - next_target_ff;
               quo_in     = start_ff - next_target_ff;
               rem_in     = '0;
               div_cnt_in = CNT_WIDTH'(TIME_WIDTH);
            end
            OP_DIV: begin
               rem_in     = rem_diff[TW] ? rem_shift[TW-1:0] : rem_diff[TW-1:0];
               quo_in     = {quo_ff[TW-2:0], 1'b0};
               div_cnt_in = div_cnt_ff - 1'b1;
            end
            OP_BASE: begin
               dur_in = end_ff - start_ff;
               case ({catch_up_ff, strict_period_ff})
                  2'b11:   base_in = next_target_ff;
                  2'b10:   base_in = next_target_ff + lat_rem;
                  2'b01:   base_in = start_ff - lat_rem;
                  default: base_in = start_ff;
               endcase
            end
            OP_TARGET: begin
               next_target_in = base_ff + period;
               last_target_in = next_target_ff;
               last_start_in  = start_ff;
               last_end_in    = end_ff;
            end
            OP_AVG: begin
               average_in = (average_ff == '0) ? dur_ff : {1'b0, avg_sum[TW-1:1]};
            end
            OP_KILL: begin
               enabled_in = 1'b0;
               destroy_in = 1'b1;
            end
            OP_LAST: dur_in = last_end_ff - last_start_ff;
            OP_PRED: begin
               pred_in = (dur_ff > average_ff) ? ({dur_ff[TW-2:0], 1'b0} - average_ff) : '0;
               late_in = last_start_ff - last_target_ff;
            end
            default: begin
               dur_in = dur_ff;
            end
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_next_target_in   = rsp_next_target_ff;
      rsp_enabled_in       = rsp_enabled_ff;
      rsp_destroyed_in     = rsp_destroyed_ff;
      rsp_trigger_total_in = rsp_trigger_total_ff;
      rsp_last_duration_in = rsp_last_duration_ff;
      rsp_mean_duration_in = rsp_mean_duration_ff;
      rsp_pred_in          = rsp_pred_ff;
      rsp_late_in          = rsp_late_ff;
      if (emit_fire) begin
         rsp_valid_in         = 1'b1;
         rsp_next_target_in   = FIELD_WIDTH'(next_target_ff);
         rsp_enabled_in       = enabled_ff;
         rsp_destroyed_in     = destroy_ff;
         rsp_trigger_total_in = run_count_ff;
         rsp_last_duration_in = FIELD_WIDTH'(dur_ff);
         rsp_mean_duration_in = FIELD_WIDTH'(average_ff);
         rsp_pred_in          = FIELD_WIDTH'(pred_ff);
         rsp_late_in          = FIELD_WIDTH'(late_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff      <= INTERVAL_RESET;
         initial_wait_ff  <= '0;
         max_triggers_ff  <= '0;
         catch_up_ff      <= 1'b0;
         strict_period_ff <= 1'b0;
         next_target_ff   <= '0;
         last_target_ff   <= '0;
         last_start_ff    <= '0;
         last_end_ff      <= '0;
         average_ff       <= '0;
         run_count_ff     <= '0;
         enabled_ff       <= 1'b0;
         destroy_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         interval_ff      <= interval_in;
         initial_wait_ff  <= initial_wait_in;
         max_triggers_ff  <= max_triggers_in;
         catch_up_ff      <= catch_up_in;
         strict_period_ff <= strict_period_in;
         next_target_ff   <= next_target_in;
         last_target_ff   <= last_target_in;
         last_start_ff    <= last_start_in;
         last_end_ff      <= last_end_in;
         average_ff       <= average_in;
         run_count_ff     <= run_count_in;
         enabled_ff       <= enabled_in;
         destroy_ff       <= destroy_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff             <= start_in;
      end_ff               <= end_in;
      lat_ff               <= lat_in;
      quo_ff               <= quo_in;
      rem_ff               <= rem_in;
      div_cnt_ff           <= div_cnt_in;
      base_ff              <= base_in;
      dur_ff               <= dur_in;
      pred_ff              <= pred_in;
      late_ff              <= late_in;
      rsp_next_target_ff   <= rsp_next_target_in;
      rsp_enabled_ff       <= rsp_enabled_in;
      rsp_destroyed_ff     <= rsp_destroyed_in;
      rsp_trigger_total_ff <= rsp_trigger_total_in;
      rsp_last_duration_ff <= rsp_last_duration_in;
      rsp_mean_duration_ff <= rsp_mean_duration_in;
      rsp_pred_ff          <= rsp_pred_in;
      rsp_late_ff          <= rsp_late_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_next_target        = rsp_next_target_ff;
   assign rsp_enabled            = rsp_enabled_ff;
   assign rsp_destroyed          = rsp_destroyed_ff;
   assign rsp_trigger_total      = rsp_trigger_total_ff;
   assign rsp_last_duration      = rsp_last_duration_ff;
   assign rsp_mean_duration      = rsp_mean_duration_ff;
   assign rsp_predicted_duration = rsp_pred_ff;
   assign rsp_start_lateness     = $signed(rsp_late_ff);

endmodule

// ===== rtl/ptdt_sequencer.sv =====
// ----------------------------------------------------------------------------
// Periodic task deadline tracker: microcode sequencer
// Step counter over a control store, with event dispatch and conditional jumps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptdt_sequencer
   import ptdt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output ctrl_type ctrl
);

   localparam ucode_type UCODE [STEP_COUNT] = '{
      '{OP_LOAD,   SEQ_DISPATCH, STEP_IDLE},
      '{OP_START,  SEQ_JUMP,     STEP_LAST},
      '{OP_STOP,   SEQ_JUMP,     STEP_LAST},
      '{OP_COUNT,  SEQ_NEXT,     STEP_IDLE},
      '{OP_LATE,   SEQ_IF_LIMIT, STEP_KILL},
      '{OP_DIV,    SEQ_LOOP,     STEP_DIV},
      '{OP_BASE,   SEQ_NEXT,     STEP_IDLE},
      '{OP_TARGET, SEQ_NEXT,     STEP_IDLE},
      '{OP_AVG,    SEQ_JUMP,     STEP_LAST},
      '{OP_KILL,   SEQ_NEXT,     STEP_IDLE},
      '{OP_LAST,   SEQ_NEXT,     STEP_IDLE},
      '{OP_PRED,   SEQ_NEXT,     STEP_IDLE},
      '{OP_EMIT,   SEQ_EMIT,     STEP_IDLE},
      '{OP_NOP,    SEQ_JUMP,     STEP_IDLE},
      '{OP_NOP,    SEQ_JUMP,     STEP_IDLE},
      '{OP_NOP,    SEQ_JUMP,     STEP_IDLE}
   };

   logic [STEP_WIDTH-1:0] step_ff;
   logic [STEP_WIDTH-1:0] step_in;
   logic [STEP_WIDTH-1:0] step_inc;
   logic [STEP_WIDTH-1:0] dispatch_step;
   ucode_type             word;

   assign word     = UCODE[step_ff];
   assign step_inc = step_ff + 1'b1;

   always_comb begin
      case (stat.func)
         FUNC_START: dispatch_step = STEP_START;
         FUNC_STOP:  dispatch_step = STEP_STOP;
         FUNC_RUN:   dispatch_step = STEP_RUN;
         default:    dispatch_step = STEP_LAST;
      endcase
   end

   always_comb begin
      ctrl.op   = word.op;
      ctrl.idle = (step_ff == STEP_IDLE);
      ctrl.fire = 1'b1;
      step_in   = step_ff;
      case (word.seq)
         SEQ_NEXT:     step_in = step_inc;
         SEQ_JUMP:     step_in = word.target;
         SEQ_IF_LIMIT: step_in = stat.limit_hit ? word.target : step_inc;
         SEQ_LOOP:     step_in = stat.div_more ? word.target : step_inc;
         SEQ_DISPATCH: begin
            ctrl.fire = stat.req_valid;
            step_in   = stat.req_valid ? dispatch_step : step_ff;
         end
         SEQ_EMIT: begin
            ctrl.fire = stat.out_free;
            step_in   = stat.out_free ? word.target : step_ff;
         end
         default:      step_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== rtl/ptdt_checker.sv =====
// ----------------------------------------------------------------------------
// Periodic task deadline tracker: port checker
// Watches the tracker's ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "periodic_task_deadline_tracker_unit_defines.svh"

module ptdt_checker
   import ptdt_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [FIELD_WIDTH-1:0] rsp_next_target,
   input logic                   rsp_destroyed,
   input logic [FIELD_WIDTH-1:0] rsp_trigger_total
);

   // hold a stalled result
   `PTDT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_next_target) && $stable(rsp_trigger_total))

   // take no second item right behind an accepted one
   `PTDT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // a fresh result comes only out of a busy cycle
   `PTDT_ASSERT_NOW(a_rsp_from_work, clock, reset, $rose(rsp_valid), $past(req_stall))

   // destroyed never drops once shown
   `PTDT_ASSERT_NEXT(a_destroy_sticky, clock, reset, rsp_valid && rsp_destroyed, rsp_destroyed)

endmodule

bind periodic_task_deadline_tracker_unit ptdt_checker u_ptdt_checker (.*);

// ===== verif/ptdt_schedule_monitor.sv =====
// ----------------------------------------------------------------------------
// Periodic task deadline tracker: schedule monitor
// Watches the register port and both item channels of the tracker, keeps its
// own copy of the task schedule and statistics, predicts the status item of
// every accepted event and compares each returned item field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptdt_schedule_monitor
   import ptdt_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_data,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [FUNC_WIDTH-1:0]         req_func,
   input  logic [FIELD_WIDTH-1:0]        req_start_time,
   input  logic [FIELD_WIDTH-1:0]        req_end_time,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [FIELD_WIDTH-1:0]        rsp_next_target,
   input  logic                          rsp_enabled,
   input  logic                          rsp_destroyed,
   input  logic [FIELD_WIDTH-1:0]        rsp_trigger_total,
   input  logic [FIELD_WIDTH-1:0]        rsp_last_duration,
   input  logic [FIELD_WIDTH-1:0]        rsp_mean_duration,
   input  logic [FIELD_WIDTH-1:0]        rsp_predicted_duration,
   input  logic signed [FIELD_WIDTH-1:0] rsp_start_lateness,
   output int                            fail_count,
   output int                            pending_count,
   output int                            checked_count
);

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] next_target;
      logic                   enabled;
      logic                   destroyed;
      logic [FIELD_WIDTH-1:0] trigger_total;
      logic [FIELD_WIDTH-1:0] last_duration;
      logic [FIELD_WIDTH-1:0] mean_duration;
      logic [FIELD_WIDTH-1:0] predicted_duration;
      logic [FIELD_WIDTH-1:0] start_lateness;
   } task_status_type;

   logic [FIELD_WIDTH-1:0] period;
   logic [FIELD_WIDTH-1:0] first_wait;
   logic [FIELD_WIDTH-1:0] trigger_limit;
   logic                   catch_up;
   logic                   strict_period;

   logic [FIELD_WIDTH-1:0] target_time;
   logic [FIELD_WIDTH-1:0] prev_target;
   logic [FIELD_WIDTH-1:0] prev_start;
   logic [FIELD_WIDTH-1:0] prev_end;
   logic [FIELD_WIDTH-1:0] mean_time;
   logic [FIELD_WIDTH-1:0] run_total;
   logic                   task_enabled;
   logic                   task_destroyed;

   task_status_type expected_status[$];
   int              fails;
   int              checks;

   function automatic task_status_type apply_event(input logic [FUNC_WIDTH-1:0] kind,
                                                   input logic [FIELD_WIDTH-1:0] s,
                                                   input logic [FIELD_WIDTH-1:0] e);
      logic [FIELD_WIDTH-1:0] t;
      logic [FIELD_WIDTH-1:0] lateness;
      logic [FIELD_WIDTH-1:0] slack;
      logic [FIELD_WIDTH-1:0] duration;
      logic [FIELD_WIDTH-1:0] sum;
      logic [FIELD_WIDTH-1:0] span;
      task_status_type        st;
      case (kind)
         FUNC_START: begin
            task_enabled = 1'b1;
            target_time  = s + first_wait;
         end
         FUNC_STOP: task_enabled = 1'b0;
         FUNC_RUN: begin
            run_total = run_total + 1'b1;
            if (trigger_limit != '0 && run_total >= trigger_limit) begin
               task_enabled   = 1'b0;
               task_destroyed = 1'b1;
            end else begin
               t        = target_time;
               lateness = s - t;
               slack    = (period == '0) ? lateness : lateness % period;
               if (catch_up && strict_period)
                  target_time = t + period;
               else if (catch_up)
                  target_time = t + slack + period;
               else if (strict_period)
                  target_time = s - slack + period;
               else
                  target_time = s + period;
               prev_target = t;
               prev_start  = s;
               prev_end    = e;
               duration    = e - s;
               sum         = mean_time + duration;
               mean_time   = (mean_time == '0) ? duration : (sum >> 1);
            end
         end
         default: ;
      endcase
      span                  = prev_end - prev_start;
      st.next_target        = target_time;
      st.enabled            = task_enabled;
      st.destroyed          = task_destroyed;
      st.trigger_total      = run_total;
      st.last_duration      = span;
      st.mean_duration      = mean_time;
      st.predicted_duration = (span <= mean_time) ? '0
                              : {span[FIELD_WIDTH-2:0], 1'b0} - mean_time;
      st.start_lateness     = prev_start - prev_target;
      return st;
   endfunction

   task automatic check_field(input string name, input logic [FIELD_WIDTH-1:0] want,
                              input logic [FIELD_WIDTH-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin : watch
      task_status_type want;
      if (reset) begin
         period         = INTERVAL_RESET;
         first_wait     = '0;
         trigger_limit  = '0;
         catch_up       = 1'b0;
         strict_period  = 1'b0;
         target_time    = '0;
         prev_target    = '0;
         prev_start     = '0;
         prev_end       = '0;
         mean_time      = '0;
         run_total      = '0;
         task_enabled   = 1'b0;
         task_destroyed = 1'b0;
         expected_status.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_INTERVAL:      period        = csr_data;
               CSR_INITIAL_WAIT:  first_wait    = csr_data;
               CSR_MAX_TRIGGERS:  trigger_limit = csr_data;
               CSR_CATCH_UP:      catch_up      = csr_data[0];
               CSR_STRICT_PERIOD: strict_period = csr_data[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_status.size() == 0) begin
               $error("status item returned with no event outstanding");
               fails++;
            end else begin
               want = expected_status.pop_front();
               checks++;
               check_field("next_target", want.next_target, rsp_next_target);
               check_field("enabled", FIELD_WIDTH'(want.enabled),
                           FIELD_WIDTH'(rsp_enabled));
               check_field("destroyed", FIELD_WIDTH'(want.destroyed),
                           FIELD_WIDTH'(rsp_destroyed));
               check_field("trigger_total", want.trigger_total, rsp_trigger_total);
               check_field("last_duration", want.last_duration, rsp_last_duration);
               check_field("mean_duration", want.mean_duration, rsp_mean_duration);
               check_field("predicted_duration", want.predicted_duration,
                           rsp_predicted_duration);
               check_field("start_lateness", want.start_lateness, rsp_start_lateness);
            end
         end
         if (req_valid && !req_stall)
            expected_status.push_back(apply_event(req_func, req_start_time, req_end_time));
      end
      fail_count    <= fails;
      pending_count <= expected_status.size();
      checked_count <= checks;
   end

endmodule

// ===== verif/tb_periodic_task_deadline_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// Periodic task deadline tracker: testbench
// Drives start, stop, run report and unused events through the tracker under
// a series of register settings (zero, unit and full-range intervals, trigger
// limits, all catch-up and strict-period modes), with random idling on both
// channels, long output hold-offs and drains before each register update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_periodic_task_deadline_tracker_unit;
   import ptdt_pkg::*;

   localparam logic [FUNC_WIDTH-1:0]  FUNC_UNUSED    = 2'd3;
   localparam logic [FIELD_WIDTH-1:0] TIME_MAX       = '1;
   localparam int                     PHASE_COUNT    = 12;
   localparam int                     PHASE_ITEMS    = 150;
   localparam int                     HOLD_CYCLES    = 300;
   localparam int                     END_CYCLES     = 60;
   localparam int                     WATCHDOG_LIMIT = 20000;

   logic                          clock;
   logic                          reset          = 1'b1;
   logic                          csr_write      = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index      = '0;
   logic [CSR_DATA_WIDTH-1:0]     csr_data       = '0;
   logic                          req_valid      = 1'b0;
   logic                          req_stall;
   logic [FUNC_WIDTH-1:0]         req_func       = '0;
   logic [FIELD_WIDTH-1:0]        req_start_time = '0;
   logic [FIELD_WIDTH-1:0]        req_end_time   = '0;
   logic                          rsp_valid;
   logic                          rsp_stall      = 1'b0;
   logic [FIELD_WIDTH-1:0]        rsp_next_target;
   logic                          rsp_enabled;
   logic                          rsp_destroyed;
   logic [FIELD_WIDTH-1:0]        rsp_trigger_total;
   logic [FIELD_WIDTH-1:0]        rsp_last_duration;
   logic [FIELD_WIDTH-1:0]        rsp_mean_duration;
   logic [FIELD_WIDTH-1:0]        rsp_predicted_duration;
   logic signed [FIELD_WIDTH-1:0] rsp_start_lateness;

   int fail_count;
   int pending_count;
   int checked_count;

   int                     send_idle_pct = 0;
   int                     recv_idle_pct = 0;
   int                     hold_asks     = 0;
   int                     items_sent    = 0;
   int                     runs_sent     = 0;
   int                     setting_count = 0;
   logic [FIELD_WIDTH-1:0] now_us        = '0;
   logic [FIELD_WIDTH-1:0] period_us     = INTERVAL_RESET;
   logic [FIELD_WIDTH-1:0] wait_us       = '0;

   periodic_task_deadline_tracker_unit dut (.*);

   ptdt_schedule_monitor schedule_monitor (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // output side: random stall, plus long hold-offs on request
   initial begin
      int holds_seen;
      int hold_left;
      holds_seen = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_asks != holds_seen) begin
            holds_seen = hold_asks;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_write || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("periodic_task_deadline_tracker_unit verification failed");
      $finish;
   end

   task automatic send_item(input logic [FUNC_WIDTH-1:0] kind,
                            input logic [FIELD_WIDTH-1:0] s,
                            input logic [FIELD_WIDTH-1:0] e);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= kind;
      req_start_time <= s;
      req_end_time   <= e;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      items_sent++;
      if (kind == FUNC_RUN)
         runs_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_settings(input logic [FIELD_WIDTH-1:0] iv,
                                 input logic [FIELD_WIDTH-1:0] iw,
                                 input logic [FIELD_WIDTH-1:0] mt,
                                 input logic cu, input logic sp);
      logic [CSR_DATA_WIDTH-1:0] junk;
      drain();
      junk = $urandom;
      csr_write <= 1'b1;
      csr_index <= CSR_INTERVAL;
      csr_data  <= iv;
      @(posedge clock);
      csr_index <= CSR_INITIAL_WAIT;
      csr_data  <= iw;
      @(posedge clock);
      csr_index <= CSR_MAX_TRIGGERS;
      csr_data  <= mt;
      @(posedge clock);
      csr_index <= CSR_CATCH_UP;
      csr_data  <= {junk[CSR_DATA_WIDTH-1:1], cu};
      @(posedge clock);
      csr_index <= CSR_STRICT_PERIOD;
      csr_data  <= {junk[CSR_DATA_WIDTH-2:0], sp};
      @(posedge clock);
      // unmapped index, must be ignored
      csr_index <= CSR_STRICT_PERIOD + CSR_INDEX_WIDTH'($urandom_range(3, 1));
      csr_data  <= $urandom;
      @(posedge clock);
      csr_write <= 1'b0;
      setting_count++;
      period_us = iv;
      wait_us   = iw;
   endtask

   // start the task, then report runs near their targets
   task automatic run_burst();
      logic [FIELD_WIDTH-1:0] base;
      logic [FIELD_WIDTH-1:0] s;
      logic [FIELD_WIDTH-1:0] dur;
      int                     n;
      now_us = now_us + $urandom_range(100000);
      send_item(FUNC_START, now_us, $urandom);
      base = now_us + wait_us;
      n    = $urandom_range(12, 1);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            6, 7:    s = base + period_us * $urandom_range(4, 1) + $urandom_range(30);
            8:       s = base - $urandom_range(50);
            9:       s = $urandom;
            default: s = base + $urandom_range(60) - 32'd20;
         endcase
         case ($urandom_range(9))
            0:       dur = '0;
            1:       dur = $urandom;
            default: dur = $urandom_range(400);
         endcase
         send_item(FUNC_RUN, s, s + dur);
         base = s + period_us;
         if ($urandom_range(19) == 0)
            send_item(FUNC_STOP, base, $urandom);
      end
      now_us = base;
      if ($urandom_range(1))
         send_item(FUNC_STOP, now_us, $urandom);
   endtask

   initial begin
      int                     phase;
      int                     phase_end;
      logic [FIELD_WIDTH-1:0] iv;
      logic [FIELD_WIDTH-1:0] iw;
      logic [FIELD_WIDTH-1:0] mt;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 11;
      recv_idle_pct = 82;

      // registers at their reset values
      send_item(FUNC_RUN, 32'd5, 32'd9);
      send_item(FUNC_START, '0, TIME_MAX);
      send_item(FUNC_RUN, 32'd1037, 32'd1137);
      send_item(FUNC_RUN, 32'd2990, 32'd3000);
      send_item(FUNC_UNUSED, TIME_MAX, TIME_MAX);
      send_item(FUNC_STOP, 32'd4000, '0);
      send_item(FUNC_RUN, TIME_MAX, '0);
      send_item(FUNC_START, TIME_MAX, '0);
      send_item(FUNC_RUN, 32'd500, 32'd100);

      // zero interval: remainder is the lateness itself
      write_settings('0, TIME_MAX, '0, 1'b1, 1'b0);
      send_item(FUNC_START, 32'd100, '0);
      send_item(FUNC_RUN, 32'd250, 32'd300);
      send_item(FUNC_RUN, 32'd180, 32'd900);
      write_settings('0, '0, '0, 1'b0, 1'b1);
      send_item(FUNC_RUN, 32'h8000_0000, 32'h8000_0010);
      send_item(FUNC_RUN, 32'h7FFF_FFFF, 32'h8000_0000);

      // trigger limit: destroy, run on, restart after destruction
      write_settings(TIME_MAX, 32'd1, runs_sent + 2, 1'b1, 1'b1);
      send_item(FUNC_RUN, 32'd10, 32'd20);
      send_item(FUNC_RUN, 32'd20, 32'd30);
      send_item(FUNC_RUN, 32'd30, 32'd40);
      send_item(FUNC_START, 32'd50, 32'd60);
      send_item(FUNC_STOP, 32'd70, 32'd80);

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase < 4) begin
            send_idle_pct = 11;
            recv_idle_pct = 82;
         end else if (phase < 8) begin
            send_idle_pct = 82;
            recv_idle_pct = 11;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (phase % 6)
            0:       iv = 32'd1;
            1:       iv = TIME_MAX;
            2:       iv = '0;
            3:       iv = $urandom;
            default: iv = $urandom_range(5000, 2);
         endcase
         case ($urandom_range(3))
            0:       iw = '0;
            1:       iw = TIME_MAX;
            2:       iw = $urandom;
            default: iw = $urandom_range(2000);
         endcase
         case ($urandom_range(7))
            0:       mt = runs_sent + $urandom_range(60, 5);
            1:       mt = TIME_MAX;
            2:       mt = runs_sent + 1;
            default: mt = '0;
         endcase
         write_settings(iv, iw, mt, phase[0], phase[1]);
         if (phase == 0 || phase == 8)
            hold_asks++;
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            case ($urandom_range(9))
               0, 1: send_item(FUNC_WIDTH'($urandom_range(3)), $urandom, $urandom);
               2: begin
                  send_item(FUNC_STOP, now_us, $urandom);
                  send_item(FUNC_RUN, now_us + period_us,
                            now_us + period_us + $urandom_range(300));
               end
               3:       send_item(FUNC_UNUSED, $urandom, $urandom);
               default: run_burst();
            endcase
         end
      end

      drain();
      repeat (END_CYCLES) @(posedge clock);
      $display("%0d status items checked over %0d register settings, all four catch-up",
               checked_count, setting_count);
      $display("and strict-period modes, zero/unit/full intervals, trigger limits hit");
      if (fail_count == 0 && pending_count == 0)
         $display("periodic_task_deadline_tracker_unit verification clean");
      else
         $display("periodic_task_deadline_tracker_unit verification failed");
      $finish;
   end

endmodule
